FILE: src/lkvc_pkg.sv
`default_nettype none

package lkvc_pkg;

    // Number of entries in the store.
    localparam int ENTRIES = 16;

    // Field widths fixed by the interface.
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 31;
    localparam int CAP_W   = 5;

    // Widths that follow from the store depth.
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Operation codes.
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    // One operation handed to the store for execution.
    typedef struct packed {
        logic               fire;
        logic               action;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } op_t;

    // Outcome of one operation.
    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
    } result_t;

endpackage

`default_nettype wire

FILE: src/lkvc_store.sv
`default_nettype none

module lkvc_store
    import lkvc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    input  wire op_t              op,
    output result_t               result
);

    logic [KEY_W-1:0]   keys_reg   [ENTRIES];
    logic [KEY_W-1:0]   keys_next  [ENTRIES];
    logic [VALUE_W-1:0] values_reg [ENTRIES];
    logic [VALUE_W-1:0] values_next[ENTRIES];
    logic [IDX_W-1:0]   ranks_reg  [ENTRIES];
    logic [IDX_W-1:0]   ranks_next [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CAP_W-1:0]   capacity_reg;

    logic [ENTRIES-1:0] match;
    logic               hit_any;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   victim_idx;
    logic [IDX_W-1:0]   last_rank;
    logic [CMP_W-1:0]   eff_cap;
    logic               full;
    logic               promote_en;
    logic               write_en;
    logic [IDX_W-1:0]   tgt_idx;
    logic [IDX_W-1:0]   old_rank;

    // Capacity of zero behaves as one; anything above the depth as the depth.
    always_comb begin
        if (capacity_reg == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(capacity_reg) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = CMP_W'(capacity_reg);
        end
    end

    assign full      = CMP_W'(count_reg) >= eff_cap;
    assign last_rank = IDX_W'(count_reg - CNT_W'(1));

    // Parallel key compare and the three lowest-index searches.
    always_comb begin
        hit_idx    = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            match[i] = valid_reg[i] && (keys_reg[i] == op.key);
            if (match[i]) begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
            if (valid_reg[i] && (ranks_reg[i] == last_rank)) begin
                victim_idx = IDX_W'(i);
            end
        end
        hit_any = |match;
    end

    // Decide which entry is touched and what rank it leaves behind.
    always_comb begin
        promote_en = 1'b0;
        write_en   = 1'b0;
        tgt_idx    = hit_idx;
        old_rank   = ranks_reg[hit_idx];
        valid_next = valid_reg;
        count_next = count_reg;
        priority if (!op.fire) begin
            promote_en = 1'b0;
        end else if (hit_any) begin
            promote_en = 1'b1;
            write_en   = (op.action == ACT_SET);
        end else if (op.action == ACT_GET) begin
            promote_en = 1'b0;
        end else if (full) begin
            promote_en = 1'b1;
            write_en   = 1'b1;
            tgt_idx    = victim_idx;
            old_rank   = last_rank;
        end else begin
            // Every valid rank lies below the count, so all valid entries age.
            promote_en           = 1'b1;
            write_en             = 1'b1;
            tgt_idx              = free_idx;
            old_rank             = IDX_W'(count_reg);
            valid_next[free_idx] = 1'b1;
            count_next           = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            keys_next[i]   = keys_reg[i];
            values_next[i] = values_reg[i];
            ranks_next[i]  = ranks_reg[i];
            if (promote_en) begin
                if (IDX_W'(i) == tgt_idx) begin
                    ranks_next[i] = '0;
                end else if (valid_reg[i] && (ranks_reg[i] < old_rank)) begin
                    ranks_next[i] = ranks_reg[i] + IDX_W'(1);
                end
            end
            if (write_en && (IDX_W'(i) == tgt_idx)) begin
                keys_next[i]   = op.key;
                values_next[i] = op.value;
            end
        end
    end

    always_comb begin
        result.hit        = hit_any;
        result.read_value = (hit_any && (op.action == ACT_GET)) ? values_reg[hit_idx] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                ranks_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            // A new capacity starts from an empty store.
            capacity_reg <= cfg_wdata;
            valid_reg    <= '0;
            count_reg    <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            ranks_reg <= ranks_next;
        end
    end

    always_ff @(posedge aclk) begin
        keys_reg   <= keys_next;
        values_reg <= values_next;
    end

endmodule

`default_nettype wire

FILE: src/lru_key_value_cache_top.sv
// Fully associative key-value cache with least-recently-used replacement.
//
// Input channel (s_valid/s_ready): one transaction carries an action (get or
// set), a 32-bit signed key and a 31-bit value. Output channel
// (m_valid/m_ready): one transaction per input transaction, in order, giving
// the hit flag and, for a get that hits, the stored value (zero otherwise).
// Configuration: cfg_we writes cfg_wdata into the capacity register in the
// same cycle; this also empties the store. The user must write it only while
// idle; the block itself does not enforce this.
//
// A transaction passes the input register and then the result register, whose
// loading raises m_valid. Throughput is one transaction per cycle while the
// receiver does not stall: the key compare over all sixteen entries and the
// rank update are combinational, so each item sees its predecessor's state.
//
// Reset (aresetn, synchronous, active low) empties the store, sets the
// capacity to sixteen and drops both valid flags. When the receiver stalls,
// the result stays held in the result register and one further input
// transaction is still taken into the input register; s_ready then falls
// until the receiver takes the waiting result.
`default_nettype none

module lru_key_value_cache_top
    import lkvc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [CAP_W-1:0]          cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_action,
    input  wire logic signed [KEY_W-1:0]   s_key,
    input  wire logic [VALUE_W-1:0]        s_value,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_hit,
    output logic [VALUE_W-1:0]             m_read_value
);

    logic               in_valid_reg;
    logic               in_action_reg;
    logic [KEY_W-1:0]   in_key_reg;
    logic [VALUE_W-1:0] in_value_reg;
    logic               out_valid_reg;
    logic               out_hit_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               fire;
    op_t                op;
    result_t            result;

    // The held item executes once the result register is free or draining.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_comb begin
        op.fire   = fire;
        op.action = in_action_reg;
        op.key    = in_key_reg;
        op.value  = in_value_reg;
    end

    lkvc_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .op        (op),
        .result    (result)
    );

    // Control flags of both registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_key_reg    <= unsigned'(s_key);
            in_value_reg  <= s_value;
        end
        if (fire) begin
            out_hit_reg   <= result.hit;
            out_value_reg <= result.read_value;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_hit        = out_hit_reg;
    assign m_read_value = out_value_reg;

endmodule

`default_nettype wire

FILE: src/lkvc_checker.sv
`default_nettype none

module lkvc_checker
    import lkvc_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_valid,
    input wire logic                    s_ready,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic                    m_hit,
    input wire logic [VALUE_W-1:0]      m_read_value
);

    // No result is offered in the cycle after reset.
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A miss never returns data.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_read_value == '0))
        else $error("nonzero read_value on a miss");

    // Input back-pressure only arises from a stalled, occupied output.
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low without an output stall");

    // A stalled result holds.
    a_output_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_hit) && $stable(m_read_value)))
        else $error("result changed while stalled");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
`default_nettype none

// Self-checking bench for the LRU key-value cache.
//
// A driver process takes access transactions from a queue that the main
// initial block fills, one phase at a time, and offers them on the input
// channel in bursts with random gaps. The same process keeps a shadow copy of
// the cache (keys, values, valid flags, recency ranks, occupancy and the
// capacity register). Whenever an input transaction is accepted it works out
// the hit flag and read value that the block must return and queues them. A
// monitor process compares each result transaction with the oldest queued
// expectation. The receiver stalls on a pattern of its own, and now and then
// it holds off for a long stretch so that the block backs up and drops
// s_ready.
//
// The capacity register is only written between phases, once every expected
// result has been seen. Each write also empties the store, and the shadow copy
// follows that.
module tb;
    import lkvc_pkg::*;

    localparam int STALL_LIMIT = 2000;  // cycles without any transaction
    localparam int HOLD_CYCLES = 80;    // length of a long receiver hold-off
    localparam int HOLD_PERIOD = 900;   // receiver cycles between hold-offs
    localparam int MAX_REPORTS = 100;   // mismatch lines printed at most

    localparam logic [KEY_W-1:0]   KEY_MIN   = 32'h8000_0000;
    localparam logic [KEY_W-1:0]   KEY_MAX   = 32'h7FFF_FFFF;
    localparam logic [KEY_W-1:0]   KEY_NEG1  = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    typedef struct packed {
        logic               action;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } access_t;

    // Block ports. Every input starts at a known value.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_action  = ACT_GET;
    logic [KEY_W-1:0]     s_key     = '0;
    logic [VALUE_W-1:0]   s_value   = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_hit;
    logic [VALUE_W-1:0]   m_read_value;

    lru_key_value_cache_top u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_hit        (m_hit),
        .m_read_value (m_read_value)
    );

    // Accesses waiting to be offered, and results still owed by the block.
    access_t pending_accesses[$];
    result_t expected_results[$];

    // Shadow copy of the cache. Rank 0 is the most recently used entry.
    logic [KEY_W-1:0]   shadow_key   [ENTRIES];
    logic [VALUE_W-1:0] shadow_val   [ENTRIES];
    bit                 shadow_valid [ENTRIES];
    int                 shadow_rank  [ENTRIES];
    int                 shadow_count;
    logic [CAP_W-1:0]   shadow_cap;

    // Run statistics and failure count.
    int n_gets = 0;
    int n_sets = 0;
    int n_hits = 0;
    int n_evictions = 0;
    int n_checked = 0;
    int n_cap_writes = 0;
    int n_errors = 0;

    // Driver and receiver bookkeeping.
    int      burst_left = 0;
    int      gap_left = 0;
    access_t next_access;
    result_t predicted;
    int      rx_cycle = 0;
    int      next_hold = HOLD_PERIOD / 2;
    int      hold_left = 0;
    int      quiet_cycles = 0;
    result_t oldest;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Capacity as the store applies it: zero acts as one, and anything beyond
    // the number of entries acts as the number of entries.
    function automatic int effective_capacity(logic [CAP_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > ENTRIES)
            return ENTRIES;
        return int'(cap);
    endfunction

    task automatic shadow_clear();
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = 0;
            shadow_key[i]   = '0;
            shadow_val[i]   = '0;
        end
        shadow_count = 0;
    endtask

    // Make entry idx the most recent; every valid entry that was newer than it
    // ages by one place.
    task automatic shadow_promote(int idx, int old_rank);
        for (int i = 0; i < ENTRIES; i++) begin
            if (i != idx && shadow_valid[i] && shadow_rank[i] < old_rank)
                shadow_rank[i] = shadow_rank[i] + 1;
        end
        shadow_rank[idx] = 0;
    endtask

    // Apply one access to the shadow cache and return the result it yields.
    task automatic lru_access(input access_t acc, output result_t res);
        int found;
        int victim;
        int best;
        int slot;
        found = -1;
        res = '0;
        if (acc.action == ACT_GET)
            n_gets++;
        else
            n_sets++;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && shadow_valid[i] && shadow_key[i] == acc.key)
                found = i;
        end
        if (found >= 0) begin
            res.hit = 1'b1;
            n_hits++;
            if (acc.action == ACT_GET)
                res.read_value = shadow_val[found];
            else
                shadow_val[found] = acc.value;
            shadow_promote(found, shadow_rank[found]);
        end else if (acc.action == ACT_SET) begin
            if (shadow_count >= effective_capacity(shadow_cap)) begin
                // Full: the entry with the highest rank is the victim.
                victim = -1;
                best = 0;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > best)) begin
                        victim = i;
                        best = shadow_rank[i];
                    end
                end
                if (victim >= 0) begin
                    shadow_key[victim] = acc.key;
                    shadow_val[victim] = acc.value;
                    shadow_promote(victim, best);
                    n_evictions++;
                end
            end else begin
                // Room left: the lowest-numbered free entry is filled.
                slot = -1;
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (!shadow_valid[i])
                        slot = i;
                end
                if (slot >= 0) begin
                    shadow_key[slot]   = acc.key;
                    shadow_val[slot]   = acc.value;
                    shadow_valid[slot] = 1'b1;
                    shadow_rank[slot]  = shadow_count;
                    shadow_count++;
                    shadow_promote(slot, shadow_rank[slot]);
                end
            end
        end
    endtask

    // Driver. It also owns the shadow cache, so that capacity writes, resets
    // and accepted transactions update it at exactly the edges where the
    // block sees them.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_action   <= ACT_GET;
            s_key      <= '0;
            s_value    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
            shadow_clear();
            shadow_cap = CAP_RESET;
        end else begin
            if (cfg_we) begin
                shadow_cap = cfg_wdata;
                shadow_clear();
            end
            if (s_valid && s_ready) begin
                lru_access('{s_action, s_key, s_value}, predicted);
                expected_results.push_back(predicted);
            end
            // A new transaction may only be offered once the current one has
            // gone; otherwise valid and the payload stay as they are.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_accesses.size() > 0) begin
                    next_access = pending_accesses.pop_front();
                    s_valid  <= 1'b1;
                    s_action <= next_access.action;
                    s_key    <= next_access.key;
                    s_value  <= next_access.value;
                    if (burst_left <= 1) begin
                        // A quarter of bursts are long and are followed by no
                        // gap at all, giving stretches of back-to-back traffic.
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left <= $urandom_range(20, 40);
                            gap_left   <= 0;
                        end else begin
                            burst_left <= $urandom_range(1, 12);
                            gap_left   <= $urandom_range(0, 5);
                        end
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. The stall pattern takes four modes in turn: always ready,
    // random, mostly stalled, and stalled only when rx_cycle is a multiple of
    // four. Every so often, while the sender is offering, it holds off for a
    // long stretch so that the block fills and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            rx_cycle  <= 0;
            hold_left <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (rx_cycle >= next_hold && s_valid) begin
                hold_left <= HOLD_CYCLES;
                next_hold <= rx_cycle + HOLD_PERIOD;
                m_ready   <= 1'b0;
            end else begin
                case ((rx_cycle / 256) % 4)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 1) == 1);
                    end
                    2: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_ready <= (rx_cycle % 4 != 0);
                    end
                endcase
            end
        end
    end

    // Monitor: every result transaction is checked against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: result with none expected: hit=%0b read_value=%0d",
                             $time, m_hit, m_read_value);
            end else begin
                oldest = expected_results.pop_front();
                n_checked++;
                if (m_hit !== oldest.hit) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: hit mismatch: expected %0b, actual %0b",
                                 $time, oldest.hit, m_hit);
                end
                if (m_read_value !== oldest.read_value) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                                 $time, oldest.read_value, m_read_value);
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic enqueue(logic act, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
        pending_accesses.push_back('{act, key, value});
    endtask

    // Wait until every queued access has been accepted and every result has
    // come back.
    task automatic wait_drained();
        while (pending_accesses.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    // Write the capacity register; the block is idle when this is called.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        n_cap_writes++;
    endtask

    // One random phase. Most accesses use a small pool of keys so that hits,
    // updates and evictions are frequent; the pool is sometimes smaller and
    // sometimes larger than the capacity. A tenth of the accesses use a fresh
    // random key, which almost always misses.
    task automatic random_phase(logic [CAP_W-1:0] cap, int count);
        logic [KEY_W-1:0]   pool[$];
        int                 pool_size;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        pool_size = $urandom_range(1, effective_capacity(cap) + 6);
        for (int i = 0; i < pool_size; i++) begin
            case ($urandom_range(0, 15))
                0: pool.push_back(KEY_MIN);
                1: pool.push_back(KEY_MAX);
                2: pool.push_back('0);
                3: pool.push_back(KEY_NEG1);
                default: pool.push_back($urandom);
            endcase
        end
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = pool[$urandom_range(0, pool_size - 1)];
            case ($urandom_range(0, 15))
                0: value = '0;
                1: value = VALUE_MAX;
                default: value = VALUE_W'($urandom);
            endcase
            enqueue($urandom_range(0, 1) ? ACT_SET : ACT_GET, key, value);
        end
        wait_drained();
    endtask

    initial begin
        logic [CAP_W-1:0] caps [10];
        caps = '{5'd1, 5'd16, 5'd31, 5'd3, 5'd0, 5'd8, 5'd17, 5'd2, 5'd5, 5'd16};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset capacity of sixteen: a get on the empty
        // store, fills with the extreme keys and values, hits on both kinds of
        // access, an overwrite, and a get that misses on a non-empty store.
        enqueue(ACT_GET, KEY_MIN, VALUE_MAX);
        enqueue(ACT_SET, KEY_MIN, VALUE_MAX);
        enqueue(ACT_SET, KEY_MAX, '0);
        enqueue(ACT_GET, KEY_MIN, '0);
        enqueue(ACT_GET, KEY_MAX, VALUE_MAX);
        enqueue(ACT_SET, KEY_MIN, 31'd5);
        enqueue(ACT_GET, KEY_MIN, '0);
        enqueue(ACT_GET, '0, '0);
        enqueue(ACT_SET, '0, 31'h2AAA_AAAA);
        enqueue(ACT_SET, KEY_NEG1, 31'h5555_5555);
        enqueue(ACT_GET, KEY_NEG1, '0);
        wait_drained();

        // A capacity of zero acts as one. The write also empties the store, so
        // a key set before it must now miss; every new key evicts the last.
        write_capacity('0);
        enqueue(ACT_GET, KEY_MIN, '0);
        enqueue(ACT_SET, 32'd11, 31'd100);
        enqueue(ACT_SET, 32'd22, 31'd200);
        enqueue(ACT_GET, 32'd11, '0);
        enqueue(ACT_GET, 32'd22, '0);
        wait_drained();

        // Capacity two: a get refreshes its entry, so the other one is the
        // one replaced by the next new key.
        write_capacity(5'd2);
        enqueue(ACT_SET, 32'd11, 31'd1);
        enqueue(ACT_SET, 32'd22, 31'd2);
        enqueue(ACT_GET, 32'd11, '0);
        enqueue(ACT_SET, 32'd33, 31'd3);
        enqueue(ACT_GET, 32'd22, '0);
        enqueue(ACT_GET, 32'd11, '0);
        enqueue(ACT_GET, 32'd33, '0);
        wait_drained();

        // Random part over a spread of capacities, the extremes among them.
        foreach (caps[i]) begin
            write_capacity(caps[i]);
            random_phase(caps[i], 100);
        end

        $display("Run covered %0d accesses (%0d gets, %0d sets) with %0d hits and %0d evictions,",
                 n_gets + n_sets, n_gets, n_sets, n_hits, n_evictions);
        $display("over %0d capacity writes; %0d results compared.", n_cap_writes, n_checked);
        if (n_errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
